[hdl/mcs_pkg.sv]
// Shared types and constants of the 8051 SFR file and interrupt unit.
// Used by mcs_front, mcs_queue, mcs_back and the top level; no dependencies.
package mcs_pkg;

  localparam int RAM_DEPTH     = 256;
  localparam int RAM_AW        = $clog2(RAM_DEPTH);
  localparam int VECTOR_BASE   = 48;
  localparam int VECTOR_STRIDE = 3;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] SFR_FIRST = 8'h80;
  localparam logic [7:0] A_SP  = 8'h81;
  localparam logic [7:0] A_DPL = 8'h82;
  localparam logic [7:0] A_DPH = 8'h83;
  localparam logic [7:0] A_IE  = 8'hA8;
  localparam logic [7:0] A_PSW = 8'hD0;
  localparam logic [7:0] A_ACC = 8'hE0;
  localparam logic [7:0] A_EIE = 8'hE8;
  localparam logic [7:0] A_B   = 8'hF0;
  localparam logic [7:0] A_EIP = 8'hF8;
  localparam logic [7:0] BIT_RAM_BASE = 8'h20;
  localparam logic [7:0] SFR_BIT_MASK = 8'hF8;

  typedef enum logic [3:0] {
    OP_RD_DIRECT = 4'd0,
    OP_WR_DIRECT = 4'd1,
    OP_RD_BIT    = 4'd2,
    OP_WR_BIT    = 4'd3,
    OP_PUSH      = 4'd4,
    OP_POP       = 4'd5,
    OP_SET_CARRY = 4'd6,
    OP_SET_DPTR  = 4'd7,
    OP_RAISE     = 4'd8,
    OP_SERVICE   = 4'd9,
    OP_RETI      = 4'd10,
    OP_TAKE_BLK  = 4'd11
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  addr;
    logic [7:0]  data;
    logic [15:0] dptr;
    logic [15:0] pc;
    logic [7:0]  target;
    logic [2:0]  bit_sel;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        bit_value;
    logic        taken;
    logic [15:0] new_pc;
    logic        fault;
  } result_t;

  function automatic logic [15:0] vector_of(input logic [2:0] line);
    logic [31:0] v;
    v = 32'(VECTOR_BASE) + 32'(VECTOR_STRIDE) * 32'(line);
    return v[15:0];
  endfunction

endpackage

[hdl/mcs_front.sv]
// Front end: unpacks an input item and resolves its target byte address.
// Depends on mcs_pkg.
module mcs_front (
  input  logic [55:0]         tdata,
  output mcs_pkg::item_t      item
);
  logic [7:0] addr;

  assign addr = tdata[11:4];

  always_comb begin
    item.op      = mcs_pkg::op_t'(tdata[3:0]);
    item.addr    = addr;
    item.data    = tdata[19:12];
    item.dptr    = tdata[35:20];
    item.pc      = tdata[51:36];
    item.bit_sel = addr[2:0];
    item.target  = addr;
    if (item.op == mcs_pkg::OP_RD_BIT || item.op == mcs_pkg::OP_WR_BIT) begin
      item.target = (addr < mcs_pkg::SFR_FIRST) ? (mcs_pkg::BIT_RAM_BASE + {3'b000, addr[7:3]})
                                                : (addr & mcs_pkg::SFR_BIT_MASK);
    end
  end
endmodule

[hdl/mcs_queue.sv]
// Two-entry queue of decoded items between front and back end.
// Depends on mcs_pkg.
module mcs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mcs_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output mcs_pkg::item_t head
);
  localparam int AW = $clog2(mcs_pkg::QUEUE_DEPTH);

  mcs_pkg::item_t entries [mcs_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;

  assign full  = count == (AW+1)'(mcs_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end
endmodule

[hdl/mcs_back.sv]
// Back end: internal RAM, SFRs and interrupt unit; executes queued items.
// Depends on mcs_pkg.
module mcs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  mcs_pkg::item_t   q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output mcs_pkg::result_t out_result
);
  typedef enum logic [2:0] {
    S_LOAD  = 3'b001,
    S_EXEC  = 3'b010,
    S_PUSH2 = 3'b100
  } state_t;

  state_t         state;
  mcs_pkg::item_t cur;

  logic [7:0] mem [mcs_pkg::RAM_DEPTH];
  logic [mcs_pkg::RAM_DEPTH-1:0] ram_valid;
  logic [7:0] ram_rdata;
  logic       ram_rvalid;
  logic [7:0] ram_raddr;
  logic       ram_we;
  logic [7:0] ram_waddr;
  logic [7:0] ram_wdata;

  logic [7:0] sp, acc, breg, dpl, dph, ie, eie, eip, pend;
  logic [7:1] psw;
  logic [1:0] lis;
  logic       vblock;

  logic        commit;
  logic [7:0]  sfr_val;
  logic        sfr_ok;
  logic        is_ram;
  logic [7:0]  byte_val;
  logic [7:0]  bit_mask;
  logic [7:0]  wr_val;
  logic        wr_en;
  logic [7:0]  enabled;
  logic [7:0]  cand;
  logic        hi_pass;
  logic        svc_take;
  logic [2:0]  svc_line;
  mcs_pkg::result_t res;

  assign q_pop  = state == S_LOAD && !q_empty;
  assign commit = state == S_EXEC && (!out_valid || out_ready);
  assign ram_raddr = (q_head.op == mcs_pkg::OP_POP) ? sp : q_head.target;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur        <= q_head;
      ram_rdata  <= mem[ram_raddr[mcs_pkg::RAM_AW-1:0]];
      ram_rvalid <= ram_valid[ram_raddr[mcs_pkg::RAM_AW-1:0]];
    end
    if (ram_we) begin
      mem[ram_waddr[mcs_pkg::RAM_AW-1:0]] <= ram_wdata;
    end
  end

  always_comb begin
    sfr_ok = 1'b1;
    case (cur.target)
      mcs_pkg::A_SP:  sfr_val = sp;
      mcs_pkg::A_DPL: sfr_val = dpl;
      mcs_pkg::A_DPH: sfr_val = dph;
      mcs_pkg::A_IE:  sfr_val = ie;
      mcs_pkg::A_PSW: sfr_val = {psw, ^acc};
      mcs_pkg::A_ACC: sfr_val = acc;
      mcs_pkg::A_B:   sfr_val = breg;
      mcs_pkg::A_EIE: sfr_val = eie;
      mcs_pkg::A_EIP: sfr_val = eip;
      default: begin
        sfr_val = 8'h00;
        sfr_ok  = 1'b0;
      end
    endcase
    is_ram   = cur.target < mcs_pkg::SFR_FIRST;
    byte_val = is_ram ? (ram_rvalid ? ram_rdata : 8'h00) : sfr_val;
    bit_mask = 8'h01 << cur.bit_sel;
    wr_val   = (cur.op == mcs_pkg::OP_WR_BIT)
               ? (cur.data[0] ? (byte_val | bit_mask) : (byte_val & ~bit_mask))
               : cur.data;
    wr_en    = (cur.op == mcs_pkg::OP_WR_DIRECT || cur.op == mcs_pkg::OP_WR_BIT)
               && (is_ram || sfr_ok);

    enabled  = pend & eie;
    hi_pass  = !lis[1];
    cand     = 8'h00;
    if (ie[7]) begin
      if (!lis[1] && (enabled & eip) != 8'h00) begin
        cand = enabled & eip;
      end else if (lis == 2'b00) begin
        cand    = enabled & ~eip;
        hi_pass = 1'b0;
      end
    end
    svc_take = cur.op == mcs_pkg::OP_SERVICE && cand != 8'h00;
    svc_line = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (cand[i]) begin
        svc_line = 3'(i);
      end
    end

    res.read_data = 8'h00;
    res.bit_value = 1'b0;
    res.taken     = 1'b0;
    res.new_pc    = cur.pc;
    res.fault     = 1'b0;
    case (cur.op)
      mcs_pkg::OP_RD_DIRECT: begin
        res.read_data = (is_ram || sfr_ok) ? byte_val : 8'h00;
        res.fault     = !(is_ram || sfr_ok);
      end
      mcs_pkg::OP_WR_DIRECT, mcs_pkg::OP_WR_BIT: begin
        res.fault = !(is_ram || sfr_ok);
      end
      mcs_pkg::OP_RD_BIT: begin
        res.bit_value = byte_val[cur.bit_sel] & (is_ram || sfr_ok);
        res.fault     = !(is_ram || sfr_ok);
      end
      mcs_pkg::OP_POP: begin
        res.read_data = ram_rvalid ? ram_rdata : 8'h00;
      end
      mcs_pkg::OP_SERVICE: begin
        res.taken = svc_take;
        if (svc_take) begin
          res.new_pc = mcs_pkg::vector_of(svc_line);
        end
      end
      mcs_pkg::OP_TAKE_BLK: begin
        res.taken = vblock;
      end
      default: begin
        res.fault = 1'b0;
      end
    endcase

    ram_we    = 1'b0;
    ram_waddr = cur.target;
    ram_wdata = wr_val;
    if (state == S_PUSH2) begin
      ram_we    = 1'b1;
      ram_waddr = sp;
      ram_wdata = cur.pc[15:8];
    end else if (commit) begin
      if (wr_en && is_ram) begin
        ram_we = 1'b1;
      end else if (cur.op == mcs_pkg::OP_PUSH) begin
        ram_we    = 1'b1;
        ram_waddr = sp + 8'd1;
        ram_wdata = cur.data;
      end else if (svc_take) begin
        ram_we    = 1'b1;
        ram_waddr = sp + 8'd1;
        ram_wdata = cur.pc[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      out_valid <= 1'b0;
      ram_valid <= '0;
      sp <= '0; acc <= '0; breg <= '0; dpl <= '0; dph <= '0;
      ie <= '0; eie <= '0; eip <= '0; pend <= '0; psw <= '0;
      lis <= '0; vblock <= 1'b0;
    end else begin
      if (ram_we) begin
        ram_valid[ram_waddr[mcs_pkg::RAM_AW-1:0]] <= 1'b1;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (q_pop) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state <= svc_take ? S_PUSH2 : S_LOAD;
            if (wr_en && !is_ram) begin
              case (cur.target)
                mcs_pkg::A_SP:  sp   <= wr_val;
                mcs_pkg::A_DPL: dpl  <= wr_val;
                mcs_pkg::A_DPH: dph  <= wr_val;
                mcs_pkg::A_IE: begin
                  ie     <= wr_val;
                  vblock <= 1'b1;
                end
                mcs_pkg::A_PSW: psw  <= wr_val[7:1];
                mcs_pkg::A_ACC: acc  <= wr_val;
                mcs_pkg::A_B:   breg <= wr_val;
                mcs_pkg::A_EIE: eie  <= wr_val;
                mcs_pkg::A_EIP: eip  <= wr_val;
                default: sp <= sp;
              endcase
            end
            case (cur.op)
              mcs_pkg::OP_PUSH:      sp <= sp + 8'd1;
              mcs_pkg::OP_POP:       sp <= sp - 8'd1;
              mcs_pkg::OP_SET_CARRY: psw[7] <= cur.data[0];
              mcs_pkg::OP_SET_DPTR: begin
                dpl <= cur.dptr[7:0];
                dph <= cur.dptr[15:8];
              end
              mcs_pkg::OP_RAISE: pend <= pend | cur.data;
              mcs_pkg::OP_SERVICE: begin
                if (svc_take) begin
                  sp   <= sp + 8'd2;
                  pend <= pend & ~(8'h01 << svc_line);
                  lis  <= lis | (hi_pass ? 2'b10 : 2'b01);
                end
              end
              mcs_pkg::OP_RETI: begin
                lis    <= lis[1] ? {1'b0, lis[0]} : 2'b00;
                vblock <= 1'b1;
              end
              mcs_pkg::OP_TAKE_BLK: vblock <= 1'b0;
              default: ;
            endcase
          end
        end
        S_PUSH2: begin
          state <= S_LOAD;
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  a_push2_after_exec: assert property (@(posedge clk) disable iff (rst)
    state == S_PUSH2 |-> $past(state == S_EXEC))
    else $error("second push without service");
  a_pop_only_load: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_LOAD)
    else $error("queue popped outside load");
  a_no_write_in_load: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD |-> !ram_we)
    else $error("RAM written in load");
  a_commit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("result lost");
endmodule

[hdl/mcs51_sfr_file_interrupt_unit_core.sv]
// Top level of the 8051 SFR file and interrupt unit.
// Depends on mcs_pkg, mcs_front, mcs_queue and mcs_back.
//
// The back end reads the RAM as it pops an item, then executes and writes;
// a serviced interrupt adds a further state for the second stack push
// through the single RAM write port. A two-entry queue keeps the input side
// accepting while the back end works or the output waits. RAM contents read
// as zero after reset through per-entry valid bits, so no clearing pass.
module mcs51_sfr_file_interrupt_unit_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // operation, address, data, dptr_value, program_counter
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // read_data, bit_value, taken, new_pc, fault
);
  mcs_pkg::item_t   dec_item;
  mcs_pkg::item_t   q_head;
  mcs_pkg::result_t res;
  logic q_full, q_empty, q_pop;

  mcs_front u_front (
    .tdata (s_tdata),
    .item  (dec_item)
  );

  mcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_item (dec_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  mcs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (res)
  );

  assign s_tready = !q_full;
  assign m_tdata  = {5'b00000, res.fault, res.new_pc, res.taken, res.bit_value, res.read_data};
endmodule

[test/mcs51_sfr_file_interrupt_unit_core_tb.sv]
// Testbench for mcs51_sfr_file_interrupt_unit_core: directed and random operations
// checked item by item against a behavioural model held in a scoreboard class.
// Depends on mcs_pkg and the RTL of the block.
module mcs51_sfr_file_interrupt_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  rd;
    logic        bv;
    logic        tk;
    logic [15:0] npc;
    logic        flt;
  } outcome_t;

  class sfr_scoreboard;
    logic [7:0] ram [256];
    logic [7:0] sp, acc, breg, psw, dpl, dph, ie, eie, eip, pend;
    logic [1:0] lvl;
    logic       vblk;
    outcome_t   pending_q [$];
    int         errors;

    function new();
      foreach (ram[i]) ram[i] = 8'h00;
      sp = 0; acc = 0; breg = 0; psw = 0; dpl = 0; dph = 0;
      ie = 0; eie = 0; eip = 0; pend = 0; lvl = 0; vblk = 0; errors = 0;
    endfunction

    function void fix_parity();
      psw[0] = ^acc;
    endfunction

    function bit get_byte(input logic [7:0] a, output logic [7:0] v);
      v = 0;
      if (a < mcs_pkg::SFR_FIRST) begin
        v = ram[a];
        return 1;
      end
      case (a)
        mcs_pkg::A_SP: v = sp;
        mcs_pkg::A_DPL: v = dpl;
        mcs_pkg::A_DPH: v = dph;
        mcs_pkg::A_IE: v = ie;
        mcs_pkg::A_PSW: v = psw;
        mcs_pkg::A_ACC: v = acc;
        mcs_pkg::A_B: v = breg;
        mcs_pkg::A_EIE: v = eie;
        mcs_pkg::A_EIP: v = eip;
        default: return 0;
      endcase
      return 1;
    endfunction

    function bit put_byte(input logic [7:0] a, input logic [7:0] v);
      if (a < mcs_pkg::SFR_FIRST) begin
        ram[a] = v;
        return 1;
      end
      case (a)
        mcs_pkg::A_SP: sp = v;
        mcs_pkg::A_DPL: dpl = v;
        mcs_pkg::A_DPH: dph = v;
        mcs_pkg::A_IE: begin
          ie = v;
          vblk = 1;
        end
        mcs_pkg::A_PSW: begin
          psw = v;
          fix_parity();
        end
        mcs_pkg::A_ACC: begin
          acc = v;
          fix_parity();
        end
        mcs_pkg::A_B: breg = v;
        mcs_pkg::A_EIE: eie = v;
        mcs_pkg::A_EIP: eip = v;
        default: return 0;
      endcase
      return 1;
    endfunction

    function void push_byte(input logic [7:0] v);
      sp = sp + 8'd1;
      ram[sp] = v;
    endfunction

    function bit take_line(input logic [15:0] pc, output logic [15:0] vec);
      logic [7:0] m;
      bit hi;
      vec = pc;
      if (!ie[7] || (pend & eie) == 0) return 0;
      for (int pass = 0; pass < 2; pass++) begin
        hi = (pass == 0);
        if (hi ? lvl[1] : (lvl != 0)) continue;
        for (int ln = 0; ln < 8; ln++) begin
          m = 8'(1 << ln);
          if ((pend & eie & m) == 0) continue;
          if (((eip & m) != 0) != hi) continue;
          pend = pend & ~m;
          push_byte(pc[7:0]);
          push_byte(pc[15:8]);
          lvl = lvl | (hi ? 2'b10 : 2'b01);
          vec = 16'(mcs_pkg::VECTOR_BASE + mcs_pkg::VECTOR_STRIDE * ln);
          return 1;
        end
      end
      return 0;
    endfunction

    function void note_item(input logic [55:0] d);
      logic [3:0]  op;
      logic [7:0]  a, dat, b, ba, m;
      logic [15:0] dp, pc;
      outcome_t    r;
      op = d[3:0]; a = d[11:4]; dat = d[19:12]; dp = d[35:20]; pc = d[51:36];
      r = '0;
      r.npc = pc;
      case (op)
        mcs_pkg::OP_RD_DIRECT: begin
          if (!get_byte(a, r.rd)) begin
            r.flt = 1;
            r.rd = 0;
          end
        end
        mcs_pkg::OP_WR_DIRECT: r.flt = !put_byte(a, dat);
        mcs_pkg::OP_RD_BIT, mcs_pkg::OP_WR_BIT: begin
          ba = (a < mcs_pkg::SFR_FIRST) ? 8'(mcs_pkg::BIT_RAM_BASE + (a >> 3))
                                        : (a & mcs_pkg::SFR_BIT_MASK);
          m = 8'(1 << a[2:0]);
          if (!get_byte(ba, b)) r.flt = 1;
          else if (op == mcs_pkg::OP_RD_BIT) r.bv = b[a[2:0]];
          else void'(put_byte(ba, dat[0] ? (b | m) : (b & ~m)));
        end
        mcs_pkg::OP_PUSH: push_byte(dat);
        mcs_pkg::OP_POP: begin
          r.rd = ram[sp];
          sp = sp - 8'd1;
        end
        mcs_pkg::OP_SET_CARRY: psw[7] = dat[0];
        mcs_pkg::OP_SET_DPTR: begin
          dpl = dp[7:0];
          dph = dp[15:8];
        end
        mcs_pkg::OP_RAISE: pend = pend | dat;
        mcs_pkg::OP_SERVICE: r.tk = take_line(pc, r.npc);
        mcs_pkg::OP_RETI: begin
          if (lvl[1]) lvl[1] = 0;
          else lvl[0] = 0;
          vblk = 1;
        end
        mcs_pkg::OP_TAKE_BLK: begin
          r.tk = vblk;
          vblk = 0;
        end
        default: ;
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_result(input logic [31:0] d);
      outcome_t e, g;
      g.rd = d[7:0]; g.bv = d[8]; g.tk = d[9]; g.npc = d[25:10]; g.flt = d[26];
      if (pending_q.size() == 0) begin
        $error("unexpected result %h", d);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (g.rd !== e.rd) begin
        $error("read_data exp %h got %h", e.rd, g.rd);
        errors++;
      end
      if (g.bv !== e.bv) begin
        $error("bit_value exp %b got %b", e.bv, g.bv);
        errors++;
      end
      if (g.tk !== e.tk) begin
        $error("taken exp %b got %b", e.tk, g.tk);
        errors++;
      end
      if (g.npc !== e.npc) begin
        $error("new_pc exp %h got %h", e.npc, g.npc);
        errors++;
      end
      if (g.flt !== e.flt) begin
        $error("fault exp %b got %b", e.flt, g.flt);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, m_tready = 0;
  logic [55:0] s_tdata = '0;
  logic s_tready, m_tvalid;
  logic [31:0] m_tdata;
  bit calm = 0;
  int idle_cycles = 0;
  sfr_scoreboard sb = new();

  mcs51_sfr_file_interrupt_unit_core dut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (rst) m_tready <= 0;
    else m_tready <= calm || ($urandom_range(99) >= 25);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [3:0] op, input logic [7:0] a, input logic [7:0] d,
                           input logic [15:0] dp, input logic [15:0] pc);
    while (!calm && $urandom_range(99) < 25) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tdata <= {4'h0, pc, dp, d, a, op};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    sb.note_item(s_tdata);
    @(negedge clk);
  endtask

  task automatic send_rand(input logic [3:0] op, input logic [7:0] a, input logic [7:0] d);
    send_item(op, a, d, 16'($urandom), 16'($urandom));
  endtask

  function automatic logic [7:0] pick_addr();
    logic [7:0] sfrs [9] = '{mcs_pkg::A_SP, mcs_pkg::A_DPL, mcs_pkg::A_DPH,
                             mcs_pkg::A_IE, mcs_pkg::A_PSW, mcs_pkg::A_ACC,
                             mcs_pkg::A_EIE, mcs_pkg::A_B, mcs_pkg::A_EIP};
    case ($urandom_range(3))
      0: return sfrs[$urandom_range(8)];
      1: return 8'($urandom_range(8'h20, 8'h2F));
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [3:0] op;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_item(mcs_pkg::OP_RD_DIRECT, 8'h00, 8'h00, 16'h0000, 16'h0000);
    send_item(mcs_pkg::OP_WR_DIRECT, 8'h7F, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_item(mcs_pkg::OP_RD_DIRECT, 8'h7F, 8'h00, 16'h0000, 16'h1234);
    send_item(mcs_pkg::OP_WR_DIRECT, 8'h80, 8'h55, 16'h0000, 16'h0000);
    send_item(mcs_pkg::OP_RD_BIT, 8'hFF, 8'h00, 16'h0000, 16'h0000);
    send_item(mcs_pkg::OP_WR_DIRECT, mcs_pkg::A_ACC, 8'h01, 16'h0000, 16'h0000);
    send_item(mcs_pkg::OP_WR_DIRECT, mcs_pkg::A_PSW, 8'h00, 16'h0000, 16'h0000);
    send_item(mcs_pkg::OP_RD_DIRECT, mcs_pkg::A_PSW, 8'h00, 16'h0000, 16'h0000);
    send_item(mcs_pkg::OP_WR_BIT, 8'h00, 8'h01, 16'h0000, 16'h0000);
    send_item(mcs_pkg::OP_WR_BIT, 8'h7F, 8'h01, 16'h0000, 16'h0000);
    send_item(mcs_pkg::OP_RD_BIT, 8'h7F, 8'h00, 16'h0000, 16'h0000);
    send_item(mcs_pkg::OP_WR_BIT, 8'hAF, 8'h01, 16'h0000, 16'h0000);
    send_item(mcs_pkg::OP_TAKE_BLK, 8'h00, 8'h00, 16'h0000, 16'h0000);
    send_item(mcs_pkg::OP_SET_CARRY, 8'h00, 8'h01, 16'h0000, 16'h0000);
    send_item(mcs_pkg::OP_SET_DPTR, 8'h00, 8'h00, 16'hFFFF, 16'h0000);
    send_item(mcs_pkg::OP_WR_DIRECT, mcs_pkg::A_SP, 8'hFF, 16'h0000, 16'h0000);
    send_item(mcs_pkg::OP_PUSH, 8'h00, 8'hA5, 16'h0000, 16'h0000);
    send_item(mcs_pkg::OP_POP, 8'h00, 8'h00, 16'h0000, 16'h0000);
    send_item(mcs_pkg::OP_WR_DIRECT, mcs_pkg::A_EIE, 8'hFF, 16'h0000, 16'h0000);
    send_item(mcs_pkg::OP_WR_DIRECT, mcs_pkg::A_EIP, 8'h80, 16'h0000, 16'h0000);
    send_item(mcs_pkg::OP_RAISE, 8'h00, 8'hFF, 16'h0000, 16'h0000);
    send_item(mcs_pkg::OP_SERVICE, 8'h00, 8'h00, 16'h0000, 16'hBEEF);
    send_item(mcs_pkg::OP_SERVICE, 8'h00, 8'h00, 16'h0000, 16'hFFFF);
    send_item(mcs_pkg::OP_RETI, 8'h00, 8'h00, 16'h0000, 16'h0000);
    send_item(4'd15, 8'hFF, 8'hFF, 16'hFFFF, 16'h4321);
    for (int n = 0; n < 1700; n++) begin
      calm = (n >= 600 && n < 800);
      if ($urandom_range(99) < 70) begin
        case ($urandom_range(9))
          0, 1: send_rand(mcs_pkg::OP_RAISE, 8'($urandom), 8'($urandom));
          2, 3: send_rand(mcs_pkg::OP_SERVICE, 8'($urandom), 8'($urandom));
          4: send_rand(mcs_pkg::OP_RETI, 8'($urandom), 8'($urandom));
          5: send_rand(mcs_pkg::OP_WR_DIRECT, mcs_pkg::A_EIP, 8'($urandom));
          6: send_rand(mcs_pkg::OP_WR_DIRECT, mcs_pkg::A_IE, 8'($urandom) | 8'h80);
          7: send_rand(mcs_pkg::OP_WR_DIRECT, mcs_pkg::A_EIE, 8'($urandom));
          8: send_rand(mcs_pkg::OP_POP, 8'($urandom), 8'($urandom));
          default: send_rand(mcs_pkg::OP_TAKE_BLK, 8'($urandom), 8'($urandom));
        endcase
      end else begin
        op = 4'($urandom_range(15));
        send_rand(op, pick_addr(), 8'($urandom));
      end
    end
    s_tvalid <= 0;
    calm = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
